@@ sv/poisson_7pt_residual_3d_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the seven-point residual block
// Concurrent checks that vanish when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef POISSON_7PT_RESIDUAL_3D_MACROS_SVH
`define POISSON_7PT_RESIDUAL_3D_MACROS_SVH

`ifndef SYNTH
`define P7R_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("p7r: implication check failed");
`define P7R_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("p7r: next-cycle check failed");
`else
`define P7R_ASSERT_IMP(label, clk, rst, ante, cons)
`define P7R_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/p7r_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// p7r_pkg
// Shared types and fixed constants of the seven-point residual block.
// ---------------------------------------------------------------------------
package p7r_pkg;

  localparam int FIELD_W    = 32;
  localparam int IDX_W      = 15;
  localparam int SIDE_W     = 6;
  localparam int INV_W      = 32;
  localparam int INV_HALF_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING = 2'd1;

  localparam int               MIN_SIDE        = 3;
  localparam int               GRID_SIDE_RST   = 32;
  localparam logic [INV_W-1:0] INV_SPACING_RST = 32'd65536;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
  } p7r_meta_t;

  localparam int META_W = $bits(p7r_meta_t);

  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } p7r_cfg_t;

endpackage

@@ sv/p7r_delay.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// p7r_delay
// Variable-length sample delay in a circular memory, stepped once per item.
// ---------------------------------------------------------------------------
module p7r_delay #(
  parameter int W  = 32,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic [AW-1:0] delay,
  input  logic [W-1:0]  din,
  output logic [W-1:0]  dout
);

  localparam int DEPTH = 1 << AW;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
    end else if (adv) begin
      wr_ptr <= wr_ptr + AW'(1);
    end
  end

  // read the old entry written delay steps ago before it can be reused
  always_ff @(posedge clk) begin
    if (adv) begin
      mem[wr_ptr] <= din;
      dout        <= mem[wr_ptr - delay];
    end
  end

endmodule

@@ sv/p7r_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// p7r_front
// Accepts samples, tracks the raster position, builds the stencil taps from
// delay memories and forms the Laplacian of each interior point.
// ---------------------------------------------------------------------------
module p7r_front #(
  parameter int MAX_SIDE = 32,
  parameter int SW       = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  p7r_pkg::p7r_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SW-1:0]          u_in,
  input  logic signed [SW-1:0]          f_in,
  input  logic [p7r_pkg::QCNT_W-1:0]    q_count,
  output logic                          push,
  output logic signed [SW+3:0]          push_lap,
  output logic signed [SW-1:0]          push_f,
  output p7r_pkg::p7r_meta_t            push_meta
);

  import p7r_pkg::*;

  localparam int NW       = $clog2(MAX_SIDE + 1);
  localparam int NNW      = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int AWB      = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int AWS      = $clog2(MAX_SIDE);
  localparam int PW       = AWS;
  localparam int LW       = SW + 4;
  localparam int CW       = QCNT_W + 1;
  localparam int RST_SIDE = (MAX_SIDE < GRID_SIDE_RST) ? MAX_SIDE : GRID_SIDE_RST;

  logic [NW-1:0]    grid_n;
  logic [NNW-1:0]   grid_nn;
  logic [PW-1:0]    plane, row, col;
  logic [PW-1:0]    plane_next, row_next, col_next;
  logic [IDX_W-1:0] pcount, pcount_next;
  logic [NW-1:0]    n_new;
  logic             accept, interior, last_pt;
  logic             col_last, row_last, plane_last;

  logic [AWB-1:0]   d_row, d_plane, d_f;
  logic [AWS-1:0]   d_col;

  logic signed [SW-1:0] t0, tap_next_row, tap_next_col, r_center, r_prev_col;
  logic signed [SW-1:0] tap_prev_row, tap_prev_plane, tap_f, r_f;
  logic                 v_a, v_b;
  p7r_meta_t            meta_a, meta_b;
  logic signed [LW-1:0] s_plane, s_row, s_col, c6;
  logic signed [SW-1:0] f_b;

  assign accept = in_valid && in_ready;
  assign in_ready = (CW'(q_count) + CW'(v_a) + CW'(v_b)) < CW'(QDEPTH);

  // clamp the written side into the supported range
  always_comb begin
    if (cfg.data[SIDE_W-1:0] < SIDE_W'(MIN_SIDE)) begin
      n_new = NW'(MIN_SIDE);
    end else if (32'(cfg.data[SIDE_W-1:0]) > 32'(MAX_SIDE)) begin
      n_new = NW'(MAX_SIDE);
    end else begin
      n_new = NW'(cfg.data[SIDE_W-1:0]);
    end
  end

  assign col_last   = NW'(col) == grid_n - NW'(1);
  assign row_last   = NW'(row) == grid_n - NW'(1);
  assign plane_last = NW'(plane) == grid_n - NW'(1);

  assign interior = (plane >= PW'(2)) && (row >= PW'(1)) && (col >= PW'(1)) &&
                    (NW'(row) < grid_n - NW'(1)) && (NW'(col) < grid_n - NW'(1));
  assign last_pt  = plane_last && (NW'(row) == grid_n - NW'(2)) &&
                    (NW'(col) == grid_n - NW'(2));

  always_comb begin
    col_next    = col + PW'(1);
    row_next    = row;
    plane_next  = plane;
    pcount_next = pcount + IDX_W'(1);
    if (col_last) begin
      col_next = '0;
      row_next = row + PW'(1);
      if (row_last) begin
        row_next   = '0;
        plane_next = plane + PW'(1);
        if (plane_last) begin
          plane_next  = '0;
          pcount_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_n  <= NW'(RST_SIDE);
      grid_nn <= NNW'(RST_SIDE * RST_SIDE);
      plane   <= '0;
      row     <= '0;
      col     <= '0;
      pcount  <= '0;
      v_a     <= 1'b0;
      v_b     <= 1'b0;
    end else begin
      if (cfg.wr && cfg.index == CFG_GRID_SIDE) begin
        // restart the frame; the delay memories keep their contents
        grid_n  <= n_new;
        grid_nn <= NNW'(n_new) * NNW'(n_new);
        plane   <= '0;
        row     <= '0;
        col     <= '0;
        pcount  <= '0;
      end else if (accept) begin
        plane  <= plane_next;
        row    <= row_next;
        col    <= col_next;
        pcount <= pcount_next;
      end
      v_a <= accept && interior;
      v_b <= v_a;
    end
  end

  // tap delays along the chain, each stage register counted in
  assign d_row   = AWB'(grid_nn - NNW'(grid_n));
  assign d_col   = AWS'(grid_n - NW'(2));
  assign d_plane = AWB'(grid_nn - NNW'(grid_n) - NNW'(1));
  assign d_f     = AWB'(grid_nn - NNW'(1));

  p7r_delay #(.W(SW), .AW(AWB)) u_dl_next_row (
    .clk(clk), .rst(rst), .adv(accept), .delay(d_row), .din(u_in), .dout(tap_next_row)
  );

  p7r_delay #(.W(SW), .AW(AWS)) u_dl_next_col (
    .clk(clk), .rst(rst), .adv(accept), .delay(d_col), .din(tap_next_row),
    .dout(tap_next_col)
  );

  p7r_delay #(.W(SW), .AW(AWS)) u_dl_prev_row (
    .clk(clk), .rst(rst), .adv(accept), .delay(d_col), .din(r_prev_col),
    .dout(tap_prev_row)
  );

  p7r_delay #(.W(SW), .AW(AWB)) u_dl_prev_plane (
    .clk(clk), .rst(rst), .adv(accept), .delay(d_plane), .din(tap_prev_row),
    .dout(tap_prev_plane)
  );

  p7r_delay #(.W(SW), .AW(AWB)) u_dl_f (
    .clk(clk), .rst(rst), .adv(accept), .delay(d_f), .din(f_in), .dout(tap_f)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      t0           <= u_in;
      r_center     <= tap_next_col;
      r_prev_col   <= r_center;
      r_f          <= tap_f;
      meta_a.index <= pcount - IDX_W'(grid_nn);
      meta_a.last  <= last_pt;
    end
  end

  // partial sums of the stencil, taken the cycle after the taps settle
  always_ff @(posedge clk) begin
    s_plane <= LW'(t0) + LW'(tap_prev_plane);
    s_row   <= LW'(tap_next_row) + LW'(tap_prev_row);
    s_col   <= LW'(tap_next_col) + LW'(r_prev_col);
    c6      <= (LW'(r_center) <<< 2) + (LW'(r_center) <<< 1);
    f_b     <= r_f;
    meta_b  <= meta_a;
  end

  assign push      = v_b;
  assign push_lap  = s_plane + s_row + s_col - c6;
  assign push_f    = f_b;
  assign push_meta = meta_b;

endmodule

@@ sv/p7r_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// p7r_queue
// Short first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
module p7r_queue #(
  parameter int W = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [W-1:0]               din,
  input  logic                       pop,
  output logic [W-1:0]               dout,
  output logic                       empty,
  output logic [p7r_pkg::QCNT_W-1:0] count
);

  import p7r_pkg::*;

  logic [W-1:0]      ent [QDEPTH];
  logic [QAW-1:0]    wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count_next;

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + QCNT_W'(1);
      2'b01:   count_next = count - QCNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= din;
    end
  end

  assign dout  = ent[rd_ptr];
  assign empty = count == '0;

endmodule

@@ sv/p7r_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// p7r_back
// Scales the Laplacian by the reciprocal spacing, subtracts it from f,
// saturates and holds the result for the receiver.
// ---------------------------------------------------------------------------
module p7r_back #(
  parameter int SW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  p7r_pkg::p7r_cfg_t    cfg,
  input  logic                 q_empty,
  input  logic signed [SW+3:0] q_lap,
  input  logic signed [SW-1:0] q_f,
  input  p7r_pkg::p7r_meta_t   q_meta,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [SW-1:0] res,
  output p7r_pkg::p7r_meta_t   res_meta
);

  import p7r_pkg::*;

  localparam int LW  = SW + 4;
  localparam int PRW = LW + INV_HALF_W + 1;
  localparam int RW  = PRW + 1;

  logic [INV_W-1:0]            inv;
  logic signed [INV_HALF_W:0]  inv_hi_s, inv_lo_s;
  logic                        en, c_vld, d_vld;
  logic signed [PRW-1:0]       prod_hi, prod_lo, scaled;
  logic signed [SW-1:0]        f_c, f_d;
  p7r_meta_t                   meta_c, meta_d;
  logic signed [RW-1:0]        diff;
  logic signed [SW-1:0]        sat;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  assign inv_hi_s = {1'b0, inv[INV_W-1:INV_HALF_W]};
  assign inv_lo_s = {1'b0, inv[INV_HALF_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      inv       <= INV_SPACING_RST;
      c_vld     <= 1'b0;
      d_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.wr && cfg.index == CFG_INV_SPACING) begin
        inv <= cfg.data;
      end
      if (en) begin
        c_vld     <= !q_empty;
        d_vld     <= c_vld;
        out_valid <= d_vld;
      end
    end
  end

  // floor of the exact product over 2^16: arithmetic shift of the low part
  always_comb begin
    diff = RW'(f_d) - RW'(scaled);
    if (&diff[RW-1:SW-1] || ~|diff[RW-1:SW-1]) begin
      sat = diff[SW-1:0];
    end else if (diff[RW-1]) begin
      sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_hi  <= q_lap * inv_hi_s;
      prod_lo  <= q_lap * inv_lo_s;
      f_c      <= q_f;
      meta_c   <= q_meta;
      scaled   <= prod_hi + (prod_lo >>> INV_HALF_W);
      f_d      <= f_c;
      meta_d   <= meta_c;
      res      <= sat;
      res_meta <= meta_d;
    end
  end

endmodule

@@ sv/poisson_7pt_residual_3d.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// poisson_7pt_residual_3d
// Seven-point Laplacian residual over a streamed cubic grid.
// ---------------------------------------------------------------------------
// Feed samples u and f in raster order (plane, row, column) on the input
// channel; the block emits one item per interior point, one plane behind the
// stream, carrying the saturated residual, the raster index and a flag on
// the final interior point of the grid. Boundary points give no item.
// Configure grid_side (index 0) and inv_spacing_sq (index 1) on the config
// channel while idle; cfg_ready is always high. Writing grid_side restarts
// the frame at position zero.
// A stencil's last input passes the tap and partial-sum registers, the queue,
// then the product, scaled and result registers. Throughput: one item per
// cycle while in_ready is high, set by the single write and read port per tap memory.
// Reset sets the position to zero, side 32 and factor 1.0; the delay memories
// are not cleared, their contents are used only after two planes arrive.
// When the receiver stalls, the back pipeline holds and a 4-entry queue
// absorbs items in flight; in_ready drops once queued plus front items fill it.
// ---------------------------------------------------------------------------
`include "poisson_7pt_residual_3d_macros.svh"

module poisson_7pt_residual_3d #(
  parameter int MAX_SIDE     = 32,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [p7r_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [p7r_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [p7r_pkg::FIELD_W-1:0]   u_sample,
  input  logic signed [p7r_pkg::FIELD_W-1:0]   f_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [p7r_pkg::FIELD_W-1:0]   residual_value,
  output logic [p7r_pkg::IDX_W-1:0]            point_index,
  output logic                                 last_interior
);

  import p7r_pkg::*;

  localparam int SW = (SAMPLE_WIDTH > FIELD_W) ? FIELD_W : SAMPLE_WIDTH;
  localparam int LW = SW + 4;
  localparam int QW = LW + SW + META_W;

  p7r_cfg_t             cfg;
  logic                 push, q_pop, q_empty;
  logic [QCNT_W-1:0]    q_count;
  logic signed [LW-1:0] push_lap;
  logic signed [SW-1:0] push_f;
  p7r_meta_t            push_meta;
  logic [QW-1:0]        q_din, q_dout;
  logic signed [SW-1:0] res;
  p7r_meta_t            res_meta;

  assign cfg_ready = 1'b1;
  assign cfg       = {cfg_valid, cfg_index, cfg_data};

  p7r_front #(.MAX_SIDE(MAX_SIDE), .SW(SW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .u_in      (u_sample[SW-1:0]),
    .f_in      (f_sample[SW-1:0]),
    .q_count   (q_count),
    .push      (push),
    .push_lap  (push_lap),
    .push_f    (push_f),
    .push_meta (push_meta)
  );

  assign q_din = {push_lap, push_f, push_meta};

  p7r_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_count)
  );

  p7r_back #(.SW(SW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_lap     (q_dout[QW-1 -: LW]),
    .q_f       (q_dout[META_W +: SW]),
    .q_meta    (p7r_meta_t'(q_dout[META_W-1:0])),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .res_meta  (res_meta)
  );

  assign residual_value = FIELD_W'(res);
  assign point_index    = res_meta.index;
  assign last_interior  = res_meta.last;

  `P7R_ASSERT_IMP(a_queue_no_overflow, clk, rst, push, q_count < QCNT_W'(QDEPTH))
  `P7R_ASSERT_IMP(a_no_pop_when_empty, clk, rst, q_pop, !q_empty)
  `P7R_ASSERT_IMP(a_ready_has_room, clk, rst, in_ready, q_count < QCNT_W'(QDEPTH))
  `P7R_ASSERT_NXT(a_push_lands, clk, rst, push && !q_pop, !q_empty)

endmodule

@@ tb/residual_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// residual_checker
// Follows the raster position and sample history of the seven-point residual
// block, predicts each interior residual and compares it with the output.
// ---------------------------------------------------------------------------
module residual_checker
  import p7r_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [FIELD_W-1:0]   u_sample,
  input  logic signed [FIELD_W-1:0]   f_sample,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [FIELD_W-1:0]   residual_value,
  input  logic [IDX_W-1:0]            point_index,
  input  logic                        last_interior,
  output int                          mismatch_count,
  output int                          pending_count
);

  localparam int HIST_AW       = 12;
  localparam int HIST_DEPTH    = 1 << HIST_AW;
  localparam int GRID_MAX_SIDE = 32;
  localparam int CENTER_WEIGHT = -6;
  localparam int FRAC_BITS     = 16;
  localparam logic signed [79:0] RES_MAX = 80'sd2147483647;
  localparam logic signed [79:0] RES_MIN = -80'sd2147483648;

  typedef struct packed {
    logic signed [FIELD_W-1:0] value;
    logic [IDX_W-1:0]          index;
    logic                      last;
  } residual_t;

  residual_t                 expected_residuals[$];
  logic signed [FIELD_W-1:0] u_hist [HIST_DEPTH];
  logic signed [FIELD_W-1:0] f_hist [HIST_DEPTH];
  int unsigned               sample_count;
  logic [SIDE_W-1:0]         side_reg;
  logic [INV_W-1:0]          inv_reg;
  int                        plane;
  int                        row;
  int                        col;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int side_in_use();
    if (side_reg < MIN_SIDE) return MIN_SIDE;
    if (side_reg > GRID_MAX_SIDE) return GRID_MAX_SIDE;
    return int'(side_reg);
  endfunction

  // u sample that arrived this many items before the current one
  function automatic logic signed [39:0] u_back(input int unsigned back);
    int unsigned pos;
    pos = sample_count - back;
    return 40'(u_hist[pos[HIST_AW-1:0]]);
  endfunction

  task automatic take_sample(input logic signed [FIELD_W-1:0] u,
                             input logic signed [FIELD_W-1:0] f);
    int                        n;
    int                        nn;
    int unsigned               pos;
    logic [31:0]               idx;
    logic signed [39:0]        lap;
    logic signed [79:0]        lap_w;
    logic signed [79:0]        inv_w;
    logic signed [79:0]        f_w;
    logic signed [79:0]        diff;
    logic signed [FIELD_W-1:0] f_center;
    residual_t                 res;
    n = side_in_use();
    nn = n * n;
    pos = sample_count;
    u_hist[pos[HIST_AW-1:0]] = u;
    f_hist[pos[HIST_AW-1:0]] = f;
    // the point one plane back is complete; emit it only when interior
    if (plane >= 2 && row >= 1 && row <= n - 2 && col >= 1 && col <= n - 2) begin
      pos = sample_count - nn;
      f_center = f_hist[pos[HIST_AW-1:0]];
      lap = u_back(0) + u_back(2 * nn) + u_back(nn - 1) + u_back(nn + 1)
          + u_back(nn - n) + u_back(nn + n) + CENTER_WEIGHT * u_back(nn);
      lap_w = 80'(lap);
      inv_w = {48'd0, inv_reg};
      f_w = 80'(f_center);
      // arithmetic shift floors toward minus infinity
      diff = f_w - ((lap_w * inv_w) >>> FRAC_BITS);
      if (diff > RES_MAX) diff = RES_MAX;
      if (diff < RES_MIN) diff = RES_MIN;
      idx = (plane - 1) * nn + row * n + col;
      res.value = diff[FIELD_W-1:0];
      res.index = idx[IDX_W-1:0];
      res.last = (plane == n - 1) && (row == n - 2) && (col == n - 2);
      expected_residuals.push_back(res);
    end
    col++;
    if (col >= n) begin
      col = 0;
      row++;
      if (row >= n) begin
        row = 0;
        plane++;
        if (plane >= n) plane = 0;
      end
    end
    sample_count++;
  endtask

  task automatic apply_write();
    if (cfg_index == CFG_GRID_SIDE) begin
      side_reg = cfg_data[SIDE_W-1:0];
      plane = 0;
      row = 0;
      col = 0;
    end else if (cfg_index == CFG_INV_SPACING) begin
      inv_reg = cfg_data[INV_W-1:0];
    end
  endtask

  task automatic check_result();
    residual_t exp_res;
    if (expected_residuals.size() == 0) begin
      report_mismatch($sformatf("unexpected item: residual %0d index %0d last %0b",
                                residual_value, point_index, last_interior));
      return;
    end
    exp_res = expected_residuals.pop_front();
    if (residual_value !== exp_res.value)
      report_mismatch($sformatf("index %0d: residual %0d, expected %0d",
                                exp_res.index, residual_value, exp_res.value));
    if (point_index !== exp_res.index)
      report_mismatch($sformatf("point_index %0d, expected %0d",
                                point_index, exp_res.index));
    if (last_interior !== exp_res.last)
      report_mismatch($sformatf("index %0d: last_interior %0b, expected %0b",
                                exp_res.index, last_interior, exp_res.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      side_reg = SIDE_W'(GRID_SIDE_RST);
      inv_reg = INV_SPACING_RST;
      plane = 0;
      row = 0;
      col = 0;
      sample_count = 0;
      expected_residuals.delete();
    end else begin
      // check before predicting so an early item cannot hide behind a new one
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) apply_write();
      if (in_valid && in_ready) take_sample(u_sample, f_sample);
    end
    pending_count = expected_residuals.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the seven-point residual block.
// ---------------------------------------------------------------------------
// One directed grid of side 3 with extreme samples, then random grids over a
// range of sides and spacing factors, including out-of-range sides and a
// short run at the largest side. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
  import p7r_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam logic [FIELD_W-1:0]   SAMPLE_MAX = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0]   SAMPLE_MIN = 32'h8000_0000;
  localparam logic [INV_W-1:0]     INV_ONE    = 32'h0001_0000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic signed [FIELD_W-1:0] u_sample = '0;
  logic signed [FIELD_W-1:0] f_sample = '0;
  logic                      out_ready = 1'b0;
  logic                      cfg_ready;
  logic                      in_ready;
  logic                      out_valid;
  logic signed [FIELD_W-1:0] residual_value;
  logic [IDX_W-1:0]          point_index;
  logic                      last_interior;
  int                        mismatch_count;
  int                        pending_count;
  bit                        steady = 1'b0;
  int                        out_stall = 0;
  logic [FIELD_W-1:0]        extremes [4] = '{SAMPLE_MAX, SAMPLE_MIN, '0, '1};

  poisson_7pt_residual_3d dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .u_sample       (u_sample),
    .f_sample       (f_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .residual_value (residual_value),
    .point_index    (point_index),
    .last_interior  (last_interior)
  );

  residual_checker residual_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .u_sample       (u_sample),
    .f_sample       (f_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .residual_value (residual_value),
    .point_index    (point_index),
    .last_interior  (last_interior),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      4, 5:       return $urandom();
      default:    return extremes[2'($urandom_range(0, 3))];
    endcase
  endfunction

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady) out_stall <= pick_gap();
    end
  end

  task automatic drive_sample(input logic [FIELD_W-1:0] u, input logic [FIELD_W-1:0] f);
    int gap;
    in_valid <= 1'b1;
    u_sample <= u;
    f_sample <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // drain every predicted item, then let non-emitting items leave the pipe
  task automatic settle();
    int w;
    in_valid <= 1'b0;
    for (w = 0; w < DRAIN_LIMIT && pending_count != 0; w++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // side below zero leaves the grid and its position untouched
  task automatic run_grid(input int side, input logic [INV_W-1:0] inv,
                          input int count, input bit calm);
    settle();
    if (side >= 0)
      write_reg(CFG_GRID_SIDE, ($urandom() & 32'hFFFF_FFC0) | 32'(side));
    write_reg(CFG_INV_SPACING, inv);
    steady <= calm;
    repeat (count) drive_sample(pick_sample(), pick_sample());
  endtask

  initial begin
    int                 p;
    logic [FIELD_W-1:0] u;
    logic [FIELD_W-1:0] f;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one side-3 grid: extreme neighbours around a minimal center saturate low
    write_reg(CFG_GRID_SIDE, 32'(MIN_SIDE));
    write_reg(CFG_INV_SPACING, INV_ONE);
    for (p = 0; p < 27; p++) begin
      case (p)
        4, 10, 12, 14, 16, 22: u = SAMPLE_MAX;
        13:                    u = SAMPLE_MIN;
        default:               u = extremes[2'(p % 4)];
      endcase
      f = (p == 13) ? SAMPLE_MAX : extremes[2'((p + 1) % 4)];
      drive_sample(u, f);
    end

    run_grid(4, INV_ONE, 100, 1'b0);
    // new spacing mid-grid, position carries on
    run_grid(-1, $urandom(), 70, 1'b0);
    // sides below the range run as side 3
    run_grid(0, 32'hFFFF_FFFF, 50, 1'b0);
    run_grid(2, 32'h0000_0000, 30, 1'b1);
    run_grid(5, 32'h0000_8000, 130, 1'b1);
    // side rewrite restarts the grid mid-frame
    run_grid(6, $urandom_range(1, 32'hFFFF), 80, 1'b0);
    run_grid($urandom_range(3, 8), $urandom(), 80, 1'b0);

    settle();
    write_reg(CFG_SPARE, $urandom());
    // above the range runs as the largest side
    run_grid(63, $urandom_range(0, 32'h0004_0000), 40, 1'b0);
    run_grid(3, $urandom(), 40, 1'b0);

    settle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
